/* hdl/fpo_pkg.sv */
// ----------------------------------------------------------------------------
// fpo_pkg
// Shared constants and helpers for the focus peaking overlay.
// ----------------------------------------------------------------------------
package fpo_pkg;

    // Largest frame the line store and the counters can hold.
    localparam int FPO_MAX_WIDTH  = 2048;
    localparam int FPO_MAX_HEIGHT = 2048;
    localparam int FPO_COL_W      = $clog2(FPO_MAX_WIDTH);
    localparam int FPO_ROW_W      = $clog2(FPO_MAX_HEIGHT);

    // Configuration register indexes.
    localparam logic [2:0] CFG_FRAME_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_FRAME_HEIGHT = 3'd1;
    localparam logic [2:0] CFG_PEAK_COLOR   = 3'd2;
    localparam logic [2:0] CFG_MONO_MODE    = 3'd3;
    localparam logic [2:0] CFG_THRESHOLD    = 3'd4;

    // Peaking color codes.
    localparam logic [2:0] PEAK_GREEN   = 3'd0;
    localparam logic [2:0] PEAK_RED     = 3'd1;
    localparam logic [2:0] PEAK_YELLOW  = 3'd2;
    localparam logic [2:0] PEAK_CYAN    = 3'd3;
    localparam logic [2:0] PEAK_MAGENTA = 3'd4;

    // Packed as {red, green, blue}.
    localparam logic [23:0] RGB_GREEN   = {8'd25,  8'd255, 8'd38};
    localparam logic [23:0] RGB_RED     = {8'd255, 8'd25,  8'd25};
    localparam logic [23:0] RGB_YELLOW  = {8'd255, 8'd242, 8'd0};
    localparam logic [23:0] RGB_CYAN    = {8'd0,   8'd230, 8'd255};
    localparam logic [23:0] RGB_MAGENTA = {8'd255, 8'd13,  8'd217};

    function automatic logic [23:0] fpo_peak_rgb(input logic [2:0] sel);
        logic [23:0] rgb;
        unique case (sel)
            PEAK_RED:     rgb = RGB_RED;
            PEAK_YELLOW:  rgb = RGB_YELLOW;
            PEAK_CYAN:    rgb = RGB_CYAN;
            PEAK_MAGENTA: rgb = RGB_MAGENTA;
            default:      rgb = RGB_GREEN;
        endcase
        return rgb;
    endfunction

    // |2c - a - b| on 8-bit luma values.
    function automatic logic [8:0] fpo_absdiff2(input logic [7:0] c, input logic [7:0] a,
                                                input logic [7:0] b);
        logic [8:0] p;
        logic [8:0] q;
        p = {c, 1'b0};
        q = {1'b0, a} + {1'b0, b};
        return (p >= q) ? (p - q) : (q - p);
    endfunction

endpackage

/* hdl/focus_peaking_overlay.sv */
// ----------------------------------------------------------------------------
// focus_peaking_overlay
// Streaming focus peaking overlay for raster-order RGB video.
// ----------------------------------------------------------------------------
// The block takes one pixel per clock unless the output stalls; for each
// pixel at column c >= 1, row r >= 1 it delivers the result for column c-1,
// row r-1, via stage one and the output register. The single line memory
// sets the rate: it is read at the new pixel's column and written back there
// as the pixel leaves stage one, and both ports can work in the same cycle.
// Interior pixels whose Laplacian edge energy |2c-l-r| + |2c-u-d| reaches
// the threshold are painted in the selected peaking color; other interior
// pixels show their source RGB, or their gray luma in mono mode. Border
// pixels are echoed with interior low. The last column and last row are
// never delivered, nor is anything for the first row or first column of
// input. The line memory needs no clearing pass; a frame must start with a
// full first line before its entries are used. The user must write
// configuration only while the stream is idle, unenforced by the block.
// ----------------------------------------------------------------------------
module focus_peaking_overlay
    import fpo_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [11:0] cfg_data,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_red,
    input  logic [7:0]  in_green,
    input  logic [7:0]  in_blue,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [10:0] out_col,
    output logic [10:0] out_row,
    output logic [7:0]  out_red,
    output logic [7:0]  out_green,
    output logic [7:0]  out_blue,
    output logic        interior,
    output logic        peaked
);

    // Configuration registers.
    logic [11:0] frame_width_reg;
    logic [11:0] frame_height_reg;
    logic [2:0]  peak_color_reg;
    logic        mono_mode_reg;
    logic [9:0]  threshold_reg;

    // Raster position of the next pixel to be accepted.
    logic [FPO_COL_W-1:0] col_count_reg, col_count_next;
    logic [FPO_ROW_W-1:0] row_count_reg, row_count_next;

    // Stage one holds the pixel whose line memory read is in flight.
    logic                 s1_valid_reg, s1_valid_next;
    logic [FPO_COL_W-1:0] s1_col_reg;
    logic [FPO_ROW_W-1:0] s1_row_reg;
    logic [23:0]          s1_rgb_reg;

    // Forwarding of a write-back that hits the entry being read at the same edge.
    logic                 fwd_reg;
    logic [39:0]          fwd_data_reg;

    // 3x3 window state: left and center luma of the line above the new one,
    // the luma two lines up, the center RGB and the luma of the previous pixel.
    logic [7:0]  win_left_reg;
    logic [7:0]  win_center_reg;
    logic [7:0]  win_up_reg;
    logic [23:0] win_rgb_reg;
    logic [7:0]  down_reg;

    // Output register.
    logic        out_valid_reg, out_valid_next;
    logic [10:0] out_col_reg;
    logic [10:0] out_row_reg;
    logic [23:0] out_rgb_reg;
    logic        interior_reg;
    logic        peaked_reg;

    logic        accept;
    logic        s1_advance;
    logic        s1_emit;
    logic [11:0] w_eff;
    logic [11:0] h_eff;
    logic [39:0] ram_rdata;
    logic [39:0] line_word;
    logic [39:0] wb_data;
    logic [7:0]  old_p;
    logic [7:0]  old_p2;
    logic [23:0] old_rgb;
    logic [9:0]  luma_sum;
    logic [7:0]  luma;
    logic [FPO_COL_W-1:0] cc;
    logic [FPO_ROW_W-1:0] rr;
    logic        inter;
    logic [9:0]  energy;
    logic        pk;
    logic [23:0] res_rgb;

    // ------------------------------------------------------------------
    // Effective frame size: zero acts as one, oversize acts as the maximum.
    // ------------------------------------------------------------------
    always_comb
    begin
        if (frame_width_reg == 12'd0)
        begin
            w_eff = 12'd1;
        end
        else if (frame_width_reg > 12'(FPO_MAX_WIDTH))
        begin
            w_eff = 12'(FPO_MAX_WIDTH);
        end
        else
        begin
            w_eff = frame_width_reg;
        end

        if (frame_height_reg == 12'd0)
        begin
            h_eff = 12'd1;
        end
        else if (frame_height_reg > 12'(FPO_MAX_HEIGHT))
        begin
            h_eff = 12'(FPO_MAX_HEIGHT);
        end
        else
        begin
            h_eff = frame_height_reg;
        end
    end

    // ------------------------------------------------------------------
    // Line memory, one word per column: {luma two up, luma one up, RGB one up}.
    // ------------------------------------------------------------------
    fpo_ram #(
        .WIDTH (40),
        .DEPTH (FPO_MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (s1_advance),
        .waddr (s1_col_reg),
        .wdata (wb_data),
        .re    (accept),
        .raddr (col_count_reg),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Stage one: window arithmetic, write-back and result formation.
    // ------------------------------------------------------------------
    always_comb
    begin
        line_word = fwd_reg ? fwd_data_reg : ram_rdata;
        old_p2    = line_word[39:32];
        old_p     = line_word[31:24];
        old_rgb   = line_word[23:0];

        luma_sum = {2'b00, s1_rgb_reg[23:16]} + {1'b0, s1_rgb_reg[15:8], 1'b0}
                 + {2'b00, s1_rgb_reg[7:0]};
        luma     = luma_sum[9:2];
        wb_data  = {old_p, luma, s1_rgb_reg};

        s1_emit = (s1_col_reg != '0) && (s1_row_reg != '0);
        cc      = s1_col_reg - FPO_COL_W'(1);
        rr      = s1_row_reg - FPO_ROW_W'(1);
        inter   = (cc != '0) && ((12'(cc) + 12'd2) <= w_eff)
               && (rr != '0) && ((12'(rr) + 12'd2) <= h_eff);

        energy = {1'b0, fpo_absdiff2(win_center_reg, win_left_reg, old_p)}
               + {1'b0, fpo_absdiff2(win_center_reg, win_up_reg, down_reg)};
        pk     = inter && (energy >= threshold_reg);

        if (pk)
        begin
            res_rgb = fpo_peak_rgb(peak_color_reg);
        end
        else if (inter && mono_mode_reg)
        begin
            res_rgb = {win_center_reg, win_center_reg, win_center_reg};
        end
        else
        begin
            res_rgb = win_rgb_reg;
        end

        // A pixel that produces no result never waits on the output.
        s1_advance = s1_valid_reg && (!s1_emit || !out_valid_reg || out_ready);
        in_ready   = !s1_valid_reg || s1_advance;
        accept     = in_valid && in_ready;
    end

    // ------------------------------------------------------------------
    // Next-state logic for counters and valid flags.
    // ------------------------------------------------------------------
    always_comb
    begin
        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        if (accept)
        begin
            if ((12'(col_count_reg) + 12'd1) >= w_eff)
            begin
                col_count_next = '0;
                if ((12'(row_count_reg) + 12'd1) >= h_eff)
                begin
                    row_count_next = '0;
                end
                else
                begin
                    row_count_next = row_count_reg + FPO_ROW_W'(1);
                end
            end
            else
            begin
                col_count_next = col_count_reg + FPO_COL_W'(1);
            end
        end

        s1_valid_next = accept || (s1_valid_reg && !s1_advance);

        out_valid_next = out_valid_reg && !out_ready;
        if (s1_advance && s1_emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Control registers.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= 12'd640;
            frame_height_reg <= 12'd480;
            peak_color_reg   <= PEAK_GREEN;
            mono_mode_reg    <= 1'b0;
            threshold_reg    <= 10'd26;
            col_count_reg    <= '0;
            row_count_reg    <= '0;
            s1_valid_reg     <= 1'b0;
            fwd_reg          <= 1'b0;
            out_valid_reg    <= 1'b0;
            win_left_reg     <= '0;
            win_center_reg   <= '0;
            win_up_reg       <= '0;
            win_rgb_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                    CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                    CFG_PEAK_COLOR:   peak_color_reg   <= cfg_data[2:0];
                    CFG_MONO_MODE:    mono_mode_reg    <= cfg_data[0];
                    CFG_THRESHOLD:    threshold_reg    <= cfg_data[9:0];
                    default:          ;
                endcase
            end
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                // Note whether the write-back at this edge lands on the entry being read.
                fwd_reg <= s1_advance && (s1_col_reg == col_count_reg);
            end
            else if (s1_advance)
            begin
                // Stage one empties, so nothing is left to forward.
                fwd_reg <= 1'b0;
            end
            if (s1_advance)
            begin
                win_left_reg   <= win_center_reg;
                win_center_reg <= old_p;
                win_up_reg     <= old_p2;
                win_rgb_reg    <= old_rgb;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_col_reg   <= col_count_reg;
            s1_row_reg   <= row_count_reg;
            s1_rgb_reg   <= {in_red, in_green, in_blue};
            fwd_data_reg <= wb_data;
        end
        if (s1_advance)
        begin
            down_reg <= luma;
        end
        if (s1_advance && s1_emit)
        begin
            out_col_reg  <= 11'(cc);
            out_row_reg  <= 11'(rr);
            out_rgb_reg  <= res_rgb;
            interior_reg <= inter;
            peaked_reg   <= pk;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_col   = out_col_reg;
    assign out_row   = out_row_reg;
    assign out_red   = out_rgb_reg[23:16];
    assign out_green = out_rgb_reg[15:8];
    assign out_blue  = out_rgb_reg[7:0];
    assign interior  = interior_reg;
    assign peaked    = peaked_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // A forwarded word always belongs to a pixel held in stage one.
    a_fwd_has_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_reg |-> s1_valid_reg)
        else $error("forwarded line word without a pixel in stage one");

    // Only interior pixels can be painted.
    a_peak_interior: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && peaked_reg) |-> interior_reg)
        else $error("peaked result on a border pixel");

    // An accepted request is held in stage one on the next cycle.
    a_accept_loads_s1: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted request lost before stage one");

    // A result waiting on a stalled output is not overwritten.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !(s1_advance && s1_emit))
        else $error("result register overwritten while stalled");

endmodule

/* hdl/fpo_ram.sv */
// ----------------------------------------------------------------------------
// fpo_ram
// Generic simple dual-port RAM with one write port and a registered read port.
// ----------------------------------------------------------------------------
module fpo_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
